// File: src/tcwc_pkg.sv
// Shared types, codes and reset constants of the congestion window control block.
`default_nettype none

package tcwc_pkg;

    // Data path width of window, threshold, budget and divider
    localparam int DATA_W = 32;
    localparam int MSS_W  = 16;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_ACK   = 2'd0,
        REQ_LOSS  = 2'd1,
        REQ_BEGIN = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SEGMENT_SIZE      = 2'd0,
        CFG_INITIAL_WINDOW    = 2'd1,
        CFG_INITIAL_THRESHOLD = 2'd2,
        CFG_UNUSED            = 2'd3
    } t_cfg_idx;

    // Reset values
    localparam logic [MSS_W-1:0]  RST_MSS       = 16'd1024;
    localparam logic [DATA_W-1:0] RST_WINDOW    = 32'd1024;
    localparam logic [DATA_W-1:0] RST_THRESHOLD = 32'd65536;
    localparam logic [1:0]        DUP_ONE       = 2'd1;
    localparam logic [1:0]        DUP_MAX       = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RECOV,
        S_CHK_GO,
        S_CHK_WAIT,
        S_CHECK,
        S_GROW,
        S_MUL,
        S_GQ_GO,
        S_GQ_WAIT,
        S_ADD,
        S_ROUND_GO,
        S_ROUND_WAIT,
        S_FIN
    } t_state;

    // Request to the shared divider
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    // Status from the shared divider
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: src/tcwc_div.sv
// Shared restoring divider, one quotient bit per cycle; a zero divisor gives all ones.
`default_nettype none

module tcwc_div import tcwc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DATA_W+1:0] w_diff;

    // Trial subtract of the shifted remainder
    assign w_diff = {1'b0, r_rem, r_quo[DATA_W-1]} - {2'b00, r_dvs};

    // Count steps and flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= CNT_W'(DATA_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift in one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_cnt != '0) begin
            if (!w_diff[DATA_W+1]) begin
                r_rem <= w_diff[DATA_W-1:0];
            end else begin
                r_rem <= {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
            end
            r_quo <= {r_quo[DATA_W-2:0], ~w_diff[DATA_W+1]};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// File: src/tcp_congestion_window_control_top.sv
// Top level of the sender-side congestion window control block.
// Use:
//   Input stream (i_s_*): one request per item; tuser holds the request kind
//   (acknowledged segment, loss report, begin transfer), tdata holds the ack
//   number and the reload flag. Output stream (o_m_*): one result per request
//   with window, threshold, avoidance flag, recovery flag and sends left.
//   Configuration channel (i_cfg_*): segment size, initial window and initial
//   threshold, written by index; always ready.
// Sequence:
//   One request at a time; o_s_tready is high only while the sequencer idles.
//   Every division runs through one shared restoring divider. Begin transfer:
//   load, then the round budget division. Segment or loss: recovery, then the
//   check division; at a round end also doubling in slow start or, in avoidance,
//   the quotient mss*mss/window, then the new round budget. Unused kind: straight to the result.
// Reset: synchronous, active low; restores the configuration defaults and
//   the transfer state, empties the output register.
// Stall: the finished result waits in the output register; a new request is
//   taken meanwhile, and its result waits in the last state until the
//   previous one has been taken.
`default_nettype none

module tcp_congestion_window_control_top import tcwc_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Input stream
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [39:0]   i_s_tdata,   // [31:0] ack_number, [32] reload_windows, zero pad
    input  wire logic [1:0]    i_s_tuser,   // [1:0] req_type
    // Output stream
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [103:0]       o_m_tdata,   // [31:0] window_bytes, [63:32] threshold_bytes,
                                            // [64] avoidance_mode, [65] recovery_due,
                                            // [97:66] sends_left, zero pad
    // Configuration write channel
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);

    t_state            r_state, n_state;

    // Configuration
    logic [MSS_W-1:0]  r_mss;
    logic [DATA_W-1:0] r_init_win;
    logic [DATA_W-1:0] r_init_thr;

    // Captured request
    t_req              r_req;
    logic [DATA_W-1:0] r_ack;
    logic              r_reload;

    // Transfer state
    logic [DATA_W-1:0] r_win, n_win;
    logic [DATA_W-1:0] r_thr, n_thr;
    logic [DATA_W-1:0] r_budget, n_budget;
    logic              r_avoid, n_avoid;
    logic [1:0]        r_dup, n_dup;
    logic [DATA_W-1:0] r_prev, n_prev;
    logic              r_recov, n_recov;
    logic [DATA_W-1:0] r_prod;

    // Output register
    logic              r_ovalid;
    logic [103:0]      r_odata;

    // Divider
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    logic [DATA_W-1:0] w_quo;

    // Arithmetic
    logic [DATA_W-1:0] w_half;
    logic [17:0]       w_mss3;
    logic [DATA_W+1:0] w_rsum;
    logic [DATA_W:0]   w_dsum;
    logic [DATA_W:0]   w_asum;
    logic [DATA_W-1:0] w_eff_budget;
    logic [DATA_W-1:0] w_dec;
    logic [1:0]        w_dup_next;
    logic              w_accept;
    logic              w_out_free;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_quo      = w_div_rsp.quotient;

    tcwc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Fast recovery sum, doubling and avoidance growth, all saturating
    assign w_half = r_win >> 1;
    assign w_mss3 = {1'b0, r_mss, 1'b0} + {2'b00, r_mss};
    assign w_rsum = {2'b00, w_half} + {{(DATA_W-16){1'b0}}, w_mss3};
    assign w_dsum = {1'b0, r_win} + {1'b0, r_win};
    assign w_asum = {1'b0, r_win} + {1'b0, w_quo};

    // Round check: budget after recovery, spent send, duplicate count
    assign w_eff_budget = r_recov ? w_quo : r_budget;
    assign w_dec        = (w_eff_budget == '0) ? '0 : w_eff_budget - 1'b1;

    always_comb begin
        w_dup_next = r_dup;
        if (r_req == REQ_ACK) begin
            if (r_ack == r_prev) begin
                w_dup_next = (r_dup == DUP_MAX) ? DUP_MAX : r_dup + 1'b1;
            end else begin
                w_dup_next = DUP_ONE;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser inside {REQ_ACK, REQ_LOSS}) begin
                        n_state = S_RECOV;
                    end else if (i_s_tuser == REQ_BEGIN) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LOAD:       n_state = S_ROUND_GO;
            S_RECOV:      n_state = S_CHK_GO;
            S_CHK_GO:     n_state = S_CHK_WAIT;
            S_CHK_WAIT:   n_state = w_div_rsp.done ? S_CHECK : S_CHK_WAIT;
            S_CHECK: begin
                if (w_dup_next != DUP_MAX && w_dec == '0) begin
                    n_state = S_GROW;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_GROW:       n_state = r_avoid ? S_MUL : S_ROUND_GO;
            S_MUL:        n_state = S_GQ_GO;
            S_GQ_GO:      n_state = S_GQ_WAIT;
            S_GQ_WAIT:    n_state = w_div_rsp.done ? S_ADD : S_GQ_WAIT;
            S_ADD:        n_state = S_ROUND_GO;
            S_ROUND_GO:   n_state = S_ROUND_WAIT;
            S_ROUND_WAIT: n_state = w_div_rsp.done ? S_FIN : S_ROUND_WAIT;
            S_FIN:        n_state = w_out_free ? S_IDLE : S_FIN;
            default:      n_state = S_IDLE;
        endcase
    end

    // Datapath updates and divider requests per state
    always_comb begin
        n_win     = r_win;
        n_thr     = r_thr;
        n_budget  = r_budget;
        n_avoid   = r_avoid;
        n_dup     = r_dup;
        n_prev    = r_prev;
        n_recov   = r_recov;
        w_div_req = '{start: 1'b0, dividend: r_win, divisor: {{(DATA_W-MSS_W){1'b0}}, r_mss}};
        case (r_state)
            S_LOAD: begin
                if (r_reload) begin
                    n_win = r_init_win;
                    n_thr = r_init_thr;
                end
                n_avoid = 1'b0;
                n_dup   = DUP_ONE;
                n_prev  = '0;
            end
            S_RECOV: begin
                n_recov = (r_dup == DUP_MAX);
                if (r_dup == DUP_MAX) begin
                    n_thr = w_half;
                    n_win = (w_rsum[DATA_W+1:DATA_W] != 2'b00) ? '1 : w_rsum[DATA_W-1:0];
                    n_dup = DUP_ONE;
                end
            end
            S_CHK_GO, S_ROUND_GO: begin
                w_div_req.start = 1'b1;
            end
            S_CHECK: begin
                if (r_win >= r_thr && w_eff_budget == w_quo) begin
                    n_avoid = 1'b1;
                end
                n_budget = w_dec;
                n_dup    = w_dup_next;
                if (r_req == REQ_ACK) begin
                    n_prev = r_ack;
                end
            end
            S_GROW: begin
                if (!r_avoid) begin
                    n_win = w_dsum[DATA_W] ? '1 : w_dsum[DATA_W-1:0];
                end
            end
            S_GQ_GO: begin
                w_div_req = '{start: 1'b1, dividend: r_prod, divisor: r_win};
            end
            S_ADD: begin
                n_win = w_asum[DATA_W] ? '1 : w_asum[DATA_W-1:0];
            end
            S_ROUND_WAIT: begin
                if (w_div_rsp.done) begin
                    n_budget = w_quo;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold control state, configuration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mss      <= RST_MSS;
            r_init_win <= RST_WINDOW;
            r_init_thr <= RST_THRESHOLD;
            r_win      <= RST_WINDOW;
            r_thr      <= RST_THRESHOLD;
            r_budget   <= '0;
            r_avoid    <= 1'b0;
            r_dup      <= DUP_ONE;
            r_prev     <= '0;
            r_recov    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_win    <= n_win;
            r_thr    <= n_thr;
            r_budget <= n_budget;
            r_avoid  <= n_avoid;
            r_dup    <= n_dup;
            r_prev   <= n_prev;
            r_recov  <= n_recov;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SEGMENT_SIZE:      r_mss      <= i_cfg_data[MSS_W-1:0];
                    CFG_INITIAL_WINDOW:    r_init_win <= i_cfg_data;
                    CFG_INITIAL_THRESHOLD: r_init_thr <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == S_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Capture the request, the square of the segment size and the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= t_req'(i_s_tuser);
            r_ack    <= i_s_tdata[31:0];
            r_reload <= i_s_tdata[32];
        end
        if (r_state == S_MUL) begin
            r_prod <= r_mss * r_mss;
        end
        if (r_state == S_FIN && w_out_free) begin
            r_odata <= {6'b0, r_budget, (r_dup == DUP_MAX), r_avoid, r_thr, r_win};
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: src/tcwc_checker.sv
// Port-level checker of the congestion window control block, bound to the top level.
`default_nettype none

module tcwc_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         o_s_tready,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [103:0] o_m_tdata
);

    // An accepted request closes the input until its work is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after a request was taken");

    // A result only appears at the end of a request's work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !$past(o_m_tvalid)) |-> !$past(o_s_tready))
        else $error("result appeared without a request in work");

    // Hold a stalled result
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result valid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("result data changed while stalled");

endmodule

bind tcp_congestion_window_control_top tcwc_checker u_tcwc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
